// ===== hw/rtl/btsp_pkg.sv =====
`timescale 1ns / 1ps

package btsp_pkg;

   localparam int unsigned HEADER_BYTES_DEFAULT = 80;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 5;
   localparam int unsigned COUNT_W = 64;

   localparam logic [BYTE_W-1:0] CSZ_PFX_2 = 8'd253;
   localparam logic [BYTE_W-1:0] CSZ_PFX_4 = 8'd254;

   localparam logic [KIND_W-1:0] KIND_HEADER       = 5'd0;
   localparam logic [KIND_W-1:0] KIND_TXCOUNT      = 5'd1;
   localparam logic [KIND_W-1:0] KIND_VERSION      = 5'd2;
   localparam logic [KIND_W-1:0] KIND_MARKER       = 5'd3;
   localparam logic [KIND_W-1:0] KIND_FLAG         = 5'd4;
   localparam logic [KIND_W-1:0] KIND_INCOUNT      = 5'd5;
   localparam logic [KIND_W-1:0] KIND_PREVHASH     = 5'd6;
   localparam logic [KIND_W-1:0] KIND_PREVINDEX    = 5'd7;
   localparam logic [KIND_W-1:0] KIND_INSCRIPTLEN  = 5'd8;
   localparam logic [KIND_W-1:0] KIND_INSCRIPT     = 5'd9;
   localparam logic [KIND_W-1:0] KIND_SEQUENCE     = 5'd10;
   localparam logic [KIND_W-1:0] KIND_OUTCOUNT     = 5'd11;
   localparam logic [KIND_W-1:0] KIND_VALUE        = 5'd12;
   localparam logic [KIND_W-1:0] KIND_OUTSCRIPTLEN = 5'd13;
   localparam logic [KIND_W-1:0] KIND_OUTSCRIPT    = 5'd14;
   localparam logic [KIND_W-1:0] KIND_WITCOUNT     = 5'd15;
   localparam logic [KIND_W-1:0] KIND_WITLEN       = 5'd16;
   localparam logic [KIND_W-1:0] KIND_WITDATA      = 5'd17;
   localparam logic [KIND_W-1:0] KIND_LOCKTIME     = 5'd18;
   localparam logic [KIND_W-1:0] KIND_TRAILING     = 5'd19;

   typedef struct packed {
      logic [BYTE_W-1:0]  byte_out;
      logic [KIND_W-1:0]  field_kind;
      logic               varint_done;
      logic [COUNT_W-1:0] varint_value;
      logic               tx_end;
      logic               block_done;
      logic               parse_error;
   } result_type;

endpackage

// ===== hw/rtl/block_transaction_stream_parser.sv =====
`timescale 1ns / 1ps

// Block transaction stream parser: takes a serialized block one byte per request, skips the
// header (HEADER_BYTES long) and tags every byte with the transaction field it belongs to,
// flagging finished compact-size values, transaction ends, the block end and a sticky
// truncation error. A byte can be accepted every cycle while responses are taken. A request
// is held in the input register from its accepting edge; once the output register is free,
// its response is registered there through the single-pass field decoder, so the input and
// output registers lie between a request and its response; a stalled response holds the
// request behind it. A new block needs a reset.
module block_transaction_stream_parser #(
   parameter int unsigned HEADER_BYTES = btsp_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [btsp_pkg::BYTE_W-1:0]      req_byte_in,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [btsp_pkg::BYTE_W-1:0]      rsp_byte_out,
   output logic [btsp_pkg::KIND_W-1:0]      rsp_field_kind,
   output logic                             rsp_varint_done,
   output logic [btsp_pkg::COUNT_W-1:0]     rsp_varint_value,
   output logic                             rsp_tx_end,
   output logic                             rsp_block_done,
   output logic                             rsp_parse_error
);

   logic                          req_valid_ff, req_valid_in;
   logic [btsp_pkg::BYTE_W-1:0]   req_byte_ff;
   logic                          req_last_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   btsp_pkg::result_type          rsp_result_ff;
   btsp_pkg::result_type          decoded;
   logic                          out_free;
   logic                          advance;
   logic                          in_load;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   btsp_fsm #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .byte_in   (req_byte_ff),
      .last_byte (req_last_ff),
      .result    (decoded)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (in_load) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         req_byte_ff <= req_byte_in;
         req_last_ff <= req_last_byte;
      end
      if (advance) begin
         rsp_result_ff <= decoded;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = rsp_result_ff.byte_out;
   assign rsp_field_kind   = rsp_result_ff.field_kind;
   assign rsp_varint_done  = rsp_result_ff.varint_done;
   assign rsp_varint_value = rsp_result_ff.varint_value;
   assign rsp_tx_end       = rsp_result_ff.tx_end;
   assign rsp_block_done   = rsp_result_ff.block_done;
   assign rsp_parse_error  = rsp_result_ff.parse_error;

endmodule

// ===== hw/rtl/btsp_fsm.sv =====
`timescale 1ns / 1ps

module btsp_fsm #(
   parameter int unsigned HEADER_BYTES = btsp_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [btsp_pkg::BYTE_W-1:0]     byte_in,
   input  logic                            last_byte,
   output btsp_pkg::result_type            result
);

   typedef enum logic [20:0] {
      PH_HEADER       = 21'h000001,
      PH_TXCOUNT      = 21'h000002,
      PH_VERSION      = 21'h000004,
      PH_FLAG         = 21'h000008,
      PH_INCOUNT      = 21'h000010,
      PH_PREVHASH     = 21'h000020,
      PH_PREVINDEX    = 21'h000040,
      PH_INSCRIPTLEN  = 21'h000080,
      PH_INSCRIPT     = 21'h000100,
      PH_SEQUENCE     = 21'h000200,
      PH_OUTCOUNT     = 21'h000400,
      PH_VALUE        = 21'h000800,
      PH_OUTSCRIPTLEN = 21'h001000,
      PH_OUTSCRIPT    = 21'h002000,
      PH_WITCOUNT     = 21'h004000,
      PH_WITLEN       = 21'h008000,
      PH_WITDATA      = 21'h010000,
      PH_LOCKTIME     = 21'h020000,
      PH_TRAILING     = 21'h040000,
      PH_INCOUNT0     = 21'h080000,
      PH_SPARE        = 21'h100000
   } phase_type;

   localparam int unsigned CW = btsp_pkg::COUNT_W;
   localparam logic [7:0] HEADER_LEN = 8'(HEADER_BYTES);

   phase_type        phase_ff, phase_in;
   logic [7:0]       fixed_left_ff, fixed_left_in;
   logic [CW-1:0]    varint_accum_ff, varint_accum_in;
   logic [3:0]       varint_left_ff, varint_left_in;
   logic [2:0]       vi_pos_ff, vi_pos_in;
   logic [CW-1:0]    txs_left_ff, txs_left_in;
   logic [CW-1:0]    inputs_total_ff, inputs_total_in;
   logic [CW-1:0]    inputs_left_ff, inputs_left_in;
   logic [CW-1:0]    outputs_left_ff, outputs_left_in;
   logic [CW-1:0]    wit_inputs_left_ff, wit_inputs_left_in;
   logic [CW-1:0]    wit_items_left_ff, wit_items_left_in;
   logic [CW-1:0]    payload_left_ff, payload_left_in;
   logic             witness_on_ff, witness_on_in;
   logic             error_seen_ff, error_seen_in;
   logic             finished_ff, finished_in;

   logic             feed_done;
   logic [CW-1:0]    feed_value;
   logic [CW-1:0]    feed_accum;
   logic [3:0]       feed_left;
   logic [2:0]       feed_pos;
   logic [CW-1:0]    feed_merged;

   logic [7:0]       fixed_dec;
   logic [CW-1:0]    txs_dec;
   logic [CW-1:0]    inputs_dec;
   logic [CW-1:0]    outputs_dec;
   logic [CW-1:0]    wit_inputs_dec;
   logic [CW-1:0]    wit_items_dec;
   logic [CW-1:0]    payload_dec;

   logic                           vdone;
   logic                           txend;
   logic                           bdone;
   logic [btsp_pkg::KIND_W-1:0]    kind;

   assign fixed_dec      = fixed_left_ff - {7'd0, |fixed_left_ff};
   assign txs_dec        = txs_left_ff - {{(CW-1){1'b0}}, |txs_left_ff};
   assign inputs_dec     = inputs_left_ff - {{(CW-1){1'b0}}, |inputs_left_ff};
   assign outputs_dec    = outputs_left_ff - {{(CW-1){1'b0}}, |outputs_left_ff};
   assign wit_inputs_dec = wit_inputs_left_ff - {{(CW-1){1'b0}}, |wit_inputs_left_ff};
   assign wit_items_dec  = wit_items_left_ff - {{(CW-1){1'b0}}, |wit_items_left_ff};
   assign payload_dec    = payload_left_ff - {{(CW-1){1'b0}}, |payload_left_ff};

   assign feed_merged = varint_accum_ff
                      | ({{(CW-8){1'b0}}, byte_in} << {vi_pos_ff, 3'b000});

   // compact-size decode, one byte per request
   always_comb begin
      feed_done  = 1'b0;
      feed_value = '0;
      feed_accum = varint_accum_ff;
      feed_left  = varint_left_ff;
      feed_pos   = vi_pos_ff;
      if (varint_left_ff == 4'd0) begin
         if (byte_in < btsp_pkg::CSZ_PFX_2) begin
            feed_done  = 1'b1;
            feed_value = {{(CW-8){1'b0}}, byte_in};
         end else begin
            feed_accum = '0;
            feed_pos   = 3'd0;
            if (byte_in == btsp_pkg::CSZ_PFX_2) begin
               feed_left = 4'd2;
            end else if (byte_in == btsp_pkg::CSZ_PFX_4) begin
               feed_left = 4'd4;
            end else begin
               feed_left = 4'd8;
            end
         end
      end else begin
         feed_accum = feed_merged;
         feed_pos   = vi_pos_ff + 3'd1;
         feed_left  = varint_left_ff - 4'd1;
         if (varint_left_ff == 4'd1) begin
            feed_done  = 1'b1;
            feed_value = feed_merged;
         end
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      fixed_left_in      = fixed_left_ff;
      varint_accum_in    = varint_accum_ff;
      varint_left_in     = varint_left_ff;
      vi_pos_in          = vi_pos_ff;
      txs_left_in        = txs_left_ff;
      inputs_total_in    = inputs_total_ff;
      inputs_left_in     = inputs_left_ff;
      outputs_left_in    = outputs_left_ff;
      wit_inputs_left_in = wit_inputs_left_ff;
      wit_items_left_in  = wit_items_left_ff;
      payload_left_in    = payload_left_ff;
      witness_on_in      = witness_on_ff;
      error_seen_in      = error_seen_ff;
      finished_in        = finished_ff;
      vdone              = 1'b0;
      txend              = 1'b0;
      bdone              = 1'b0;
      kind               = btsp_pkg::KIND_TRAILING;

      unique case (phase_ff) inside
         PH_HEADER: begin
            kind          = btsp_pkg::KIND_HEADER;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               phase_in = PH_TXCOUNT;
            end
         end
         PH_TXCOUNT: begin
            kind           = btsp_pkg::KIND_TXCOUNT;
            vdone          = feed_done;
            varint_accum_in = feed_accum;
            varint_left_in = feed_left;
            vi_pos_in      = feed_pos;
            if (feed_done) begin
               txs_left_in = feed_value;
               if (feed_value == '0) begin
                  finished_in = 1'b1;
                  bdone       = 1'b1;
                  phase_in    = PH_TRAILING;
               end else begin
                  phase_in      = PH_VERSION;
                  fixed_left_in = 8'd4;
               end
            end
         end
         PH_VERSION: begin
            kind          = btsp_pkg::KIND_VERSION;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               phase_in        = PH_INCOUNT0;
               witness_on_in   = 1'b0;
               inputs_total_in = '0;
            end
         end
         PH_INCOUNT0, PH_INCOUNT: begin
            if (phase_ff == PH_INCOUNT0 && varint_left_ff == 4'd0 && byte_in == 8'd0) begin
               kind = btsp_pkg::KIND_MARKER;
            end else begin
               kind = btsp_pkg::KIND_INCOUNT;
            end
            vdone           = feed_done;
            varint_accum_in = feed_accum;
            varint_left_in  = feed_left;
            vi_pos_in       = feed_pos;
            if (feed_done) begin
               inputs_total_in = feed_value;
               inputs_left_in  = feed_value;
               if (feed_value != '0) begin
                  phase_in      = PH_PREVHASH;
                  fixed_left_in = 8'd32;
               end else if (phase_ff == PH_INCOUNT0) begin
                  phase_in = PH_FLAG;
               end else begin
                  phase_in = PH_OUTCOUNT;
               end
            end
         end
         PH_FLAG: begin
            kind          = btsp_pkg::KIND_FLAG;
            witness_on_in = byte_in[0];
            if (byte_in != 8'd0) begin
               phase_in = PH_INCOUNT;
            end else begin
               outputs_left_in = '0;
               phase_in        = PH_LOCKTIME;
               fixed_left_in   = 8'd4;
            end
         end
         PH_PREVHASH: begin
            kind          = btsp_pkg::KIND_PREVHASH;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               phase_in      = PH_PREVINDEX;
               fixed_left_in = 8'd4;
            end
         end
         PH_PREVINDEX: begin
            kind          = btsp_pkg::KIND_PREVINDEX;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               phase_in = PH_INSCRIPTLEN;
            end
         end
         PH_INSCRIPTLEN: begin
            kind            = btsp_pkg::KIND_INSCRIPTLEN;
            vdone           = feed_done;
            varint_accum_in = feed_accum;
            varint_left_in  = feed_left;
            vi_pos_in       = feed_pos;
            if (feed_done) begin
               payload_left_in = feed_value;
               if (feed_value != '0) begin
                  phase_in = PH_INSCRIPT;
               end else begin
                  phase_in      = PH_SEQUENCE;
                  fixed_left_in = 8'd4;
               end
            end
         end
         PH_INSCRIPT: begin
            kind            = btsp_pkg::KIND_INSCRIPT;
            payload_left_in = payload_dec;
            if (payload_dec == '0) begin
               phase_in      = PH_SEQUENCE;
               fixed_left_in = 8'd4;
            end
         end
         PH_SEQUENCE: begin
            kind          = btsp_pkg::KIND_SEQUENCE;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               inputs_left_in = inputs_dec;
               if (inputs_dec != '0) begin
                  phase_in      = PH_PREVHASH;
                  fixed_left_in = 8'd32;
               end else begin
                  phase_in = PH_OUTCOUNT;
               end
            end
         end
         PH_OUTCOUNT: begin
            kind            = btsp_pkg::KIND_OUTCOUNT;
            vdone           = feed_done;
            varint_accum_in = feed_accum;
            varint_left_in  = feed_left;
            vi_pos_in       = feed_pos;
            if (feed_done) begin
               outputs_left_in = feed_value;
               if (feed_value != '0) begin
                  phase_in      = PH_VALUE;
                  fixed_left_in = 8'd8;
               end else if (witness_on_ff && inputs_total_ff != '0) begin
                  wit_inputs_left_in = inputs_total_ff;
                  phase_in           = PH_WITCOUNT;
               end else begin
                  phase_in      = PH_LOCKTIME;
                  fixed_left_in = 8'd4;
               end
            end
         end
         PH_VALUE: begin
            kind          = btsp_pkg::KIND_VALUE;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               phase_in = PH_OUTSCRIPTLEN;
            end
         end
         PH_OUTSCRIPTLEN, PH_OUTSCRIPT: begin
            if (phase_ff == PH_OUTSCRIPTLEN) begin
               kind            = btsp_pkg::KIND_OUTSCRIPTLEN;
               vdone           = feed_done;
               varint_accum_in = feed_accum;
               varint_left_in  = feed_left;
               vi_pos_in       = feed_pos;
               if (feed_done) begin
                  payload_left_in = feed_value;
               end
            end else begin
               kind            = btsp_pkg::KIND_OUTSCRIPT;
               payload_left_in = payload_dec;
            end
            if (phase_ff == PH_OUTSCRIPTLEN && feed_done && feed_value != '0) begin
               phase_in = PH_OUTSCRIPT;
            end else if ((phase_ff == PH_OUTSCRIPTLEN && feed_done)
                         || (phase_ff == PH_OUTSCRIPT && payload_dec == '0)) begin
               outputs_left_in = outputs_dec;
               if (outputs_dec != '0) begin
                  phase_in      = PH_VALUE;
                  fixed_left_in = 8'd8;
               end else if (witness_on_ff && inputs_total_ff != '0) begin
                  wit_inputs_left_in = inputs_total_ff;
                  phase_in           = PH_WITCOUNT;
               end else begin
                  phase_in      = PH_LOCKTIME;
                  fixed_left_in = 8'd4;
               end
            end
         end
         PH_WITCOUNT: begin
            kind            = btsp_pkg::KIND_WITCOUNT;
            vdone           = feed_done;
            varint_accum_in = feed_accum;
            varint_left_in  = feed_left;
            vi_pos_in       = feed_pos;
            if (feed_done) begin
               wit_items_left_in = feed_value;
               if (feed_value != '0) begin
                  phase_in = PH_WITLEN;
               end else begin
                  wit_inputs_left_in = wit_inputs_dec;
                  if (wit_inputs_dec != '0) begin
                     phase_in = PH_WITCOUNT;
                  end else begin
                     phase_in      = PH_LOCKTIME;
                     fixed_left_in = 8'd4;
                  end
               end
            end
         end
         PH_WITLEN, PH_WITDATA: begin
            if (phase_ff == PH_WITLEN) begin
               kind            = btsp_pkg::KIND_WITLEN;
               vdone           = feed_done;
               varint_accum_in = feed_accum;
               varint_left_in  = feed_left;
               vi_pos_in       = feed_pos;
               if (feed_done) begin
                  payload_left_in = feed_value;
               end
            end else begin
               kind            = btsp_pkg::KIND_WITDATA;
               payload_left_in = payload_dec;
            end
            if (phase_ff == PH_WITLEN && feed_done && feed_value != '0) begin
               phase_in = PH_WITDATA;
            end else if ((phase_ff == PH_WITLEN && feed_done)
                         || (phase_ff == PH_WITDATA && payload_dec == '0)) begin
               wit_items_left_in = wit_items_dec;
               if (wit_items_dec != '0) begin
                  phase_in = PH_WITLEN;
               end else begin
                  wit_inputs_left_in = wit_inputs_dec;
                  if (wit_inputs_dec != '0) begin
                     phase_in = PH_WITCOUNT;
                  end else begin
                     phase_in      = PH_LOCKTIME;
                     fixed_left_in = 8'd4;
                  end
               end
            end
         end
         PH_LOCKTIME: begin
            kind          = btsp_pkg::KIND_LOCKTIME;
            fixed_left_in = fixed_dec;
            if (fixed_dec == 8'd0) begin
               txend       = 1'b1;
               txs_left_in = txs_dec;
               if (txs_dec == '0) begin
                  finished_in = 1'b1;
                  bdone       = 1'b1;
                  phase_in    = PH_TRAILING;
               end else begin
                  phase_in      = PH_VERSION;
                  fixed_left_in = 8'd4;
               end
            end
         end
         default: begin
            kind     = btsp_pkg::KIND_TRAILING;
            phase_in = PH_TRAILING;
         end
      endcase

      if (last_byte) begin
         if (!finished_in) begin
            error_seen_in = 1'b1;
         end
         phase_in       = PH_TRAILING;
         varint_left_in = 4'd0;
      end
   end

   assign result.byte_out     = byte_in;
   assign result.field_kind   = kind;
   assign result.varint_done  = vdone;
   assign result.varint_value = vdone ? feed_value : '0;
   assign result.tx_end       = txend;
   assign result.block_done   = bdone;
   assign result.parse_error  = error_seen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= (HEADER_LEN == 8'd0) ? PH_TXCOUNT : PH_HEADER;
         fixed_left_ff      <= HEADER_LEN;
         varint_accum_ff    <= '0;
         varint_left_ff     <= 4'd0;
         vi_pos_ff          <= 3'd0;
         txs_left_ff        <= '0;
         inputs_total_ff    <= '0;
         inputs_left_ff     <= '0;
         outputs_left_ff    <= '0;
         wit_inputs_left_ff <= '0;
         wit_items_left_ff  <= '0;
         payload_left_ff    <= '0;
         witness_on_ff      <= 1'b0;
         error_seen_ff      <= 1'b0;
         finished_ff        <= 1'b0;
      end else if (advance) begin
         phase_ff           <= phase_in;
         fixed_left_ff      <= fixed_left_in;
         varint_accum_ff    <= varint_accum_in;
         varint_left_ff     <= varint_left_in;
         vi_pos_ff          <= vi_pos_in;
         txs_left_ff        <= txs_left_in;
         inputs_total_ff    <= inputs_total_in;
         inputs_left_ff     <= inputs_left_in;
         outputs_left_ff    <= outputs_left_in;
         wit_inputs_left_ff <= wit_inputs_left_in;
         wit_items_left_ff  <= wit_items_left_in;
         payload_left_ff    <= payload_left_in;
         witness_on_ff      <= witness_on_in;
         error_seen_ff      <= error_seen_in;
         finished_ff        <= finished_in;
      end
   end

endmodule

// ===== test/btsp_field_tag_checker.sv =====
`timescale 1ns / 1ps

module btsp_field_tag_checker #(
   parameter int unsigned HEADER_BYTES = btsp_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [btsp_pkg::BYTE_W-1:0]  req_byte_in,
   input  logic                         req_last_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [btsp_pkg::BYTE_W-1:0]  rsp_byte_out,
   input  logic [btsp_pkg::KIND_W-1:0]  rsp_field_kind,
   input  logic                         rsp_varint_done,
   input  logic [btsp_pkg::COUNT_W-1:0] rsp_varint_value,
   input  logic                         rsp_tx_end,
   input  logic                         rsp_block_done,
   input  logic                         rsp_parse_error,
   output int                           tag_errors,
   output int                           tags_waiting
);

   localparam int unsigned CW = btsp_pkg::COUNT_W;

   typedef enum logic [4:0] {
      ST_HEADER       = 5'd0,
      ST_TXCOUNT      = 5'd1,
      ST_VERSION      = 5'd2,
      ST_FLAG         = 5'd4,
      ST_INCOUNT      = 5'd5,
      ST_PREVHASH     = 5'd6,
      ST_PREVINDEX    = 5'd7,
      ST_INSCRIPTLEN  = 5'd8,
      ST_INSCRIPT     = 5'd9,
      ST_SEQUENCE     = 5'd10,
      ST_OUTCOUNT     = 5'd11,
      ST_VALUE        = 5'd12,
      ST_OUTSCRIPTLEN = 5'd13,
      ST_OUTSCRIPT    = 5'd14,
      ST_WITCOUNT     = 5'd15,
      ST_WITLEN       = 5'd16,
      ST_WITDATA      = 5'd17,
      ST_LOCKTIME     = 5'd18,
      ST_TRAILING     = 5'd19,
      ST_INCOUNT0     = 5'd20
   } walk_state_type;

   walk_state_type     walk;
   logic [7:0]         fix_cnt;
   logic [CW-1:0]      csz_acc;
   logic [3:0]         csz_left;
   logic [2:0]         csz_pos;
   logic [CW-1:0]      tx_cnt;
   logic [CW-1:0]      in_total;
   logic [CW-1:0]      in_cnt;
   logic [CW-1:0]      out_cnt;
   logic [CW-1:0]      wit_in_cnt;
   logic [CW-1:0]      wit_item_cnt;
   logic [CW-1:0]      data_cnt;
   logic               wit_on;
   logic               err_flag;
   logic               done_flag;

   btsp_pkg::result_type tags_due[$];
   int                   errs = 0;

   task automatic csz_take(input logic [7:0] b, output bit got,
                           output logic [CW-1:0] val);
      got = 1'b0;
      val = '0;
      if (csz_left == 4'd0) begin
         if (b < btsp_pkg::CSZ_PFX_2) begin
            val = CW'(b);
            got = 1'b1;
         end else begin
            csz_left = (b == btsp_pkg::CSZ_PFX_2) ? 4'd2 :
                       (b == btsp_pkg::CSZ_PFX_4) ? 4'd4 : 4'd8;
            csz_acc  = '0;
            csz_pos  = '0;
         end
      end else begin
         csz_acc  = csz_acc | (CW'(b) << (8 * csz_pos));
         csz_pos  = csz_pos + 3'd1;
         csz_left = csz_left - 4'd1;
         if (csz_left == 4'd0) begin
            val = csz_acc;
            got = 1'b1;
         end
      end
   endtask

   task automatic start_fixed(input walk_state_type s, input logic [7:0] n);
      walk    = s;
      fix_cnt = n;
   endtask

   task automatic close_wit_input();
      if (wit_in_cnt != 0) wit_in_cnt = wit_in_cnt - 1;
      if (wit_in_cnt != 0) walk = ST_WITCOUNT;
      else start_fixed(ST_LOCKTIME, 8'd4);
   endtask

   task automatic close_wit_item();
      if (wit_item_cnt != 0) wit_item_cnt = wit_item_cnt - 1;
      if (wit_item_cnt != 0) walk = ST_WITLEN;
      else close_wit_input();
   endtask

   task automatic close_outputs();
      if (wit_on && in_total != 0) begin
         wit_in_cnt = in_total;
         walk       = ST_WITCOUNT;
      end else begin
         start_fixed(ST_LOCKTIME, 8'd4);
      end
   endtask

   task automatic close_output();
      if (out_cnt != 0) out_cnt = out_cnt - 1;
      if (out_cnt != 0) start_fixed(ST_VALUE, 8'd8);
      else close_outputs();
   endtask

   task automatic tag_next_byte(input logic [7:0] b, input logic is_last,
                                output btsp_pkg::result_type r);
      logic [btsp_pkg::KIND_W-1:0] kind;
      bit                          got;
      logic [CW-1:0]               val;
      bit                          tx_done;
      bit                          blk_done;
      kind     = walk;
      got      = 1'b0;
      val      = '0;
      tx_done  = 1'b0;
      blk_done = 1'b0;
      if (walk == ST_INCOUNT0)
         kind = (csz_left == 4'd0 && b == 8'd0) ? btsp_pkg::KIND_MARKER
                                                : btsp_pkg::KIND_INCOUNT;
      case (walk) inside
         ST_HEADER: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) walk = ST_TXCOUNT;
         end
         ST_TXCOUNT: begin
            csz_take(b, got, val);
            if (got) begin
               tx_cnt = val;
               if (val == 0) begin
                  done_flag = 1'b1;
                  blk_done  = 1'b1;
                  walk      = ST_TRAILING;
               end else begin
                  start_fixed(ST_VERSION, 8'd4);
               end
            end
         end
         ST_VERSION: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) begin
               walk     = ST_INCOUNT0;
               wit_on   = 1'b0;
               in_total = '0;
            end
         end
         ST_INCOUNT0, ST_INCOUNT: begin
            csz_take(b, got, val);
            if (got) begin
               in_total = val;
               in_cnt   = val;
               if (val != 0) start_fixed(ST_PREVHASH, 8'd32);
               else if (walk == ST_INCOUNT0) walk = ST_FLAG;
               else walk = ST_OUTCOUNT;
            end
         end
         ST_FLAG: begin
            wit_on = b[0];
            if (b != 8'd0) begin
               walk = ST_INCOUNT;
            end else begin
               out_cnt = '0;
               start_fixed(ST_LOCKTIME, 8'd4);
            end
         end
         ST_PREVHASH: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) start_fixed(ST_PREVINDEX, 8'd4);
         end
         ST_PREVINDEX: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) walk = ST_INSCRIPTLEN;
         end
         ST_INSCRIPTLEN: begin
            csz_take(b, got, val);
            if (got) begin
               data_cnt = val;
               if (val != 0) walk = ST_INSCRIPT;
               else start_fixed(ST_SEQUENCE, 8'd4);
            end
         end
         ST_INSCRIPT: begin
            if (data_cnt != 0) data_cnt = data_cnt - 1;
            if (data_cnt == 0) start_fixed(ST_SEQUENCE, 8'd4);
         end
         ST_SEQUENCE: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) begin
               if (in_cnt != 0) in_cnt = in_cnt - 1;
               if (in_cnt != 0) start_fixed(ST_PREVHASH, 8'd32);
               else walk = ST_OUTCOUNT;
            end
         end
         ST_OUTCOUNT: begin
            csz_take(b, got, val);
            if (got) begin
               out_cnt = val;
               if (val != 0) start_fixed(ST_VALUE, 8'd8);
               else close_outputs();
            end
         end
         ST_VALUE: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) walk = ST_OUTSCRIPTLEN;
         end
         ST_OUTSCRIPTLEN: begin
            csz_take(b, got, val);
            if (got) begin
               data_cnt = val;
               if (val != 0) walk = ST_OUTSCRIPT;
               else close_output();
            end
         end
         ST_OUTSCRIPT: begin
            if (data_cnt != 0) data_cnt = data_cnt - 1;
            if (data_cnt == 0) close_output();
         end
         ST_WITCOUNT: begin
            csz_take(b, got, val);
            if (got) begin
               wit_item_cnt = val;
               if (val != 0) walk = ST_WITLEN;
               else close_wit_input();
            end
         end
         ST_WITLEN: begin
            csz_take(b, got, val);
            if (got) begin
               data_cnt = val;
               if (val != 0) walk = ST_WITDATA;
               else close_wit_item();
            end
         end
         ST_WITDATA: begin
            if (data_cnt != 0) data_cnt = data_cnt - 1;
            if (data_cnt == 0) close_wit_item();
         end
         ST_LOCKTIME: begin
            if (fix_cnt != 0) fix_cnt = fix_cnt - 8'd1;
            if (fix_cnt == 0) begin
               tx_done = 1'b1;
               if (tx_cnt != 0) tx_cnt = tx_cnt - 1;
               if (tx_cnt == 0) begin
                  done_flag = 1'b1;
                  blk_done  = 1'b1;
                  walk      = ST_TRAILING;
               end else begin
                  start_fixed(ST_VERSION, 8'd4);
               end
            end
         end
         default: begin
            kind = btsp_pkg::KIND_TRAILING;
            walk = ST_TRAILING;
         end
      endcase
      if (is_last) begin
         if (!done_flag) err_flag = 1'b1;
         walk     = ST_TRAILING;
         csz_left = '0;
      end
      r.byte_out     = b;
      r.field_kind   = kind;
      r.varint_done  = got;
      r.varint_value = got ? val : '0;
      r.tx_end       = tx_done;
      r.block_done   = blk_done;
      r.parse_error  = err_flag;
   endtask

   task automatic check_field(input string what, input logic [CW-1:0] want,
                              input logic [CW-1:0] got);
      if (got !== want) begin
         errs++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      btsp_pkg::result_type want;
      if (reset) begin
         fix_cnt      = HEADER_BYTES[7:0];
         walk         = (fix_cnt != 0) ? ST_HEADER : ST_TXCOUNT;
         csz_acc      = '0;
         csz_left     = '0;
         csz_pos      = '0;
         tx_cnt       = '0;
         in_total     = '0;
         in_cnt       = '0;
         out_cnt      = '0;
         wit_in_cnt   = '0;
         wit_item_cnt = '0;
         data_cnt     = '0;
         wit_on       = 1'b0;
         err_flag     = 1'b0;
         done_flag    = 1'b0;
         tags_due.delete();
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            tag_next_byte(req_byte_in, req_last_byte, want);
            tags_due.push_back(want);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (tags_due.size() == 0) begin
               errs++;
               $display("%0t: unexpected response: expected none, got byte %0h kind %0d",
                        $time, rsp_byte_out, rsp_field_kind);
            end else begin
               want = tags_due.pop_front();
               check_field("byte_out", CW'(want.byte_out), CW'(rsp_byte_out));
               check_field("field_kind", CW'(want.field_kind), CW'(rsp_field_kind));
               check_field("varint_done", CW'(want.varint_done), CW'(rsp_varint_done));
               check_field("varint_value", want.varint_value, rsp_varint_value);
               check_field("tx_end", CW'(want.tx_end), CW'(rsp_tx_end));
               check_field("block_done", CW'(want.block_done), CW'(rsp_block_done));
               check_field("parse_error", CW'(want.parse_error), CW'(rsp_parse_error));
            end
         end
      end
      tag_errors   <= errs;
      tags_waiting <= tags_due.size();
   end

endmodule

// ===== test/block_transaction_stream_parser_tb.sv =====
`timescale 1ns / 1ps

module block_transaction_stream_parser_tb;

   localparam int unsigned CW           = btsp_pkg::COUNT_W;
   localparam int unsigned HDR_BYTES    = btsp_pkg::HEADER_BYTES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned ITEM_TARGET  = 850;
   localparam int unsigned TX_BUDGET    = 700;
   localparam int unsigned TRAIL_BYTES  = 30;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam logic [btsp_pkg::BYTE_W-1:0] CSZ_PFX_8 = 8'd255;

   typedef enum int {END_EMPTY, END_IN_HEADER, END_TRUNCATED, END_COMPLETE} block_end_type;
   typedef enum int {
      TX_LEGACY, TX_SEGWIT, TX_FLAG_ZERO, TX_FLAG_EVEN, TX_LONG_MARKER
   } tx_style_type;
   typedef enum int {CSZ_SHORT, CSZ_WIDE2, CSZ_WIDE4, CSZ_WIDE8} csz_form_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [btsp_pkg::BYTE_W-1:0]   req_byte_in   = '0;
   logic                          req_last_byte = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [btsp_pkg::BYTE_W-1:0]   rsp_byte_out;
   logic [btsp_pkg::KIND_W-1:0]   rsp_field_kind;
   logic                          rsp_varint_done;
   logic [CW-1:0]                 rsp_varint_value;
   logic                          rsp_tx_end;
   logic                          rsp_block_done;
   logic                          rsp_parse_error;

   int          tag_errors;
   int          tags_waiting;
   int          recv_pct = 0;
   int unsigned cycles   = 0;

   logic [7:0] blk[$];
   bit         last_q[$];

   block_transaction_stream_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_field_kind   (rsp_field_kind),
      .rsp_varint_done  (rsp_varint_done),
      .rsp_varint_value (rsp_varint_value),
      .rsp_tx_end       (rsp_tx_end),
      .rsp_block_done   (rsp_block_done),
      .rsp_parse_error  (rsp_parse_error)
   );

   btsp_field_tag_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_byte_in      (req_byte_in),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_field_kind   (rsp_field_kind),
      .rsp_varint_done  (rsp_varint_done),
      .rsp_varint_value (rsp_varint_value),
      .rsp_tx_end       (rsp_tx_end),
      .rsp_block_done   (rsp_block_done),
      .rsp_parse_error  (rsp_parse_error),
      .tag_errors       (tag_errors),
      .tags_waiting     (tags_waiting)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("** block_transaction_stream_parser: FAILED **");
         $finish;
      end
   end

   function automatic csz_form_type pick_form();
      if ($urandom_range(0, 7) != 0) return CSZ_SHORT;
      return csz_form_type'($urandom_range(1, 3));
   endfunction

   function automatic int pick_payload_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
   endfunction

   task automatic emit_csz(input logic [CW-1:0] v, input csz_form_type form);
      int n;
      case (form)
         CSZ_WIDE2: n = 2;
         CSZ_WIDE4: n = 4;
         CSZ_WIDE8: n = 8;
         default: begin
            if (v < 253) n = 0;
            else if (v < 64'h1_0000) n = 2;
            else if (v < 64'h1_0000_0000) n = 4;
            else n = 8;
         end
      endcase
      if (n == 0) begin
         blk.push_back(v[7:0]);
      end else begin
         blk.push_back(n == 2 ? btsp_pkg::CSZ_PFX_2 : n == 4 ? btsp_pkg::CSZ_PFX_4 : CSZ_PFX_8);
         for (int i = 0; i < n; i++) blk.push_back(v[8*i +: 8]);
      end
   endtask

   initial begin
      block_end_type      ending;
      tx_style_type       style;
      logic [7:0]         body[$];
      logic [7:0]         flag;
      logic [CW-1:0]      count;
      bit                 wit;
      bit                 mark_end;
      int                 r, ntx, cut, blen, n, gap_pct;
      int                 n_in, n_out, n_items, len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      r = $urandom_range(0, 9);
      if (r == 0) ending = END_EMPTY;
      else if (r == 1) ending = END_IN_HEADER;
      else if (r < 5) ending = END_TRUNCATED;
      else ending = END_COMPLETE;

      // transactions first, the first five one of each shape
      ntx = 0;
      while ((ending == END_TRUNCATED || ending == END_COMPLETE) && blk.size() < TX_BUDGET) begin
         if (ntx < 5) begin
            style = tx_style_type'(ntx);
         end else begin
            r = $urandom_range(0, 9);
            if (r < 4) style = TX_LEGACY;
            else if (r < 8) style = TX_SEGWIT;
            else if (r == 8) style = TX_FLAG_EVEN;
            else style = $urandom_range(0, 1) ? TX_FLAG_ZERO : TX_LONG_MARKER;
         end
         wit  = 1'b0;
         n_in = 0;
         flag = 8'h00;
         repeat (4) blk.push_back(8'($urandom));
         case (style) inside
            TX_LEGACY: begin
               n_in = $urandom_range(1, 2);
               emit_csz(CW'(n_in), pick_form());
            end
            TX_SEGWIT, TX_LONG_MARKER: begin
               if (style == TX_SEGWIT) blk.push_back(8'h00);
               else emit_csz(64'd0, csz_form_type'($urandom_range(1, 3)));
               flag = $urandom_range(0, 1) ? 8'h01 : (8'($urandom) | 8'h01);
               wit  = 1'b1;
            end
            TX_FLAG_EVEN: begin
               blk.push_back(8'h00);
               flag = 8'($urandom) & 8'hFE;
               if (flag == 8'h00) flag = 8'h02;
            end
            default: begin
               blk.push_back(8'h00);
               blk.push_back(8'h00);
            end
         endcase
         if (style != TX_LEGACY && style != TX_FLAG_ZERO) begin
            blk.push_back(flag);
            n_in = $urandom_range(0, 2);
            emit_csz(CW'(n_in), pick_form());
         end
         if (style != TX_FLAG_ZERO) begin
            for (int i = 0; i < n_in; i++) begin
               repeat (36) blk.push_back(8'($urandom));
               len = pick_payload_len();
               emit_csz(CW'(len), pick_form());
               repeat (len) blk.push_back(8'($urandom));
               repeat (4) blk.push_back(8'($urandom));
            end
            n_out = $urandom_range(0, 3);
            emit_csz(CW'(n_out), pick_form());
            for (int i = 0; i < n_out; i++) begin
               repeat (8) blk.push_back(8'($urandom));
               len = pick_payload_len();
               emit_csz(CW'(len), pick_form());
               repeat (len) blk.push_back(8'($urandom));
            end
            if (wit) begin
               for (int i = 0; i < n_in; i++) begin
                  n_items = $urandom_range(0, 3);
                  emit_csz(CW'(n_items), pick_form());
                  for (int j = 0; j < n_items; j++) begin
                     len = $urandom_range(0, 4);
                     emit_csz(CW'(len), pick_form());
                     repeat (len) blk.push_back(8'($urandom));
                  end
               end
            end
         end
         repeat (4) blk.push_back(8'($urandom));
         ntx++;
      end

      // header and, unless the block ends inside it, the count go in front
      body = blk;
      blk.delete();
      for (int i = 0; i < HDR_BYTES; i++) blk.push_back(8'($urandom));
      blk[0] = 8'h00;
      blk[1] = 8'hFF;
      case (ending)
         END_EMPTY: emit_csz(64'd0, pick_form());
         END_IN_HEADER: begin
            cut = $urandom_range(0, 1) ? HDR_BYTES : $urandom_range(1, HDR_BYTES);
            while (blk.size() > cut) void'(blk.pop_back());
         end
         END_TRUNCATED: begin
            count = {$urandom, $urandom};
            if (count <= ntx) count = ~count;
            emit_csz(count, CSZ_WIDE8);
            blk = {blk, body};
            repeat ($urandom_range(0, 40)) blk.push_back(8'($urandom));
         end
         default: begin
            emit_csz(CW'(ntx), pick_form());
            blk = {blk, body};
         end
      endcase
      mark_end = (ending == END_IN_HEADER || ending == END_TRUNCATED) || $urandom_range(0, 1);
      blen = blk.size();
      for (int i = 0; i < blen; i++) last_q.push_back(i == blen - 1 ? mark_end : 1'b0);
      repeat (TRAIL_BYTES) begin
         blk.push_back(8'($urandom));
         last_q.push_back($urandom_range(0, 3) == 0);
      end
      while (blk.size() < ITEM_TARGET) begin
         blk.push_back(8'($urandom));
         last_q.push_back($urandom_range(0, 3) == 0);
      end

      n = blk.size();
      for (int i = 0; i < n; i++) begin
         if (i < n / 3) begin
            gap_pct = 11;
            recv_pct <= 75;
         end else if (i < 2 * n / 3) begin
            gap_pct = 75;
            recv_pct <= 11;
         end else begin
            gap_pct = 0;
            recv_pct <= 0;
         end
         while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_byte_in   <= blk[i];
         req_last_byte <= last_q[i];
         do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (tags_waiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tag_errors == 0 && tags_waiting == 0)
         $display("** block_transaction_stream_parser: PASSED **");
      else
         $display("** block_transaction_stream_parser: FAILED **");
      $finish;
   end

endmodule
